/* src/evu_pkg.sv */
// Shared types and constants for the encoder velocity averager.
// No dependencies; every other file in src refers to this package by scoped names.
`default_nettype none
package evu_pkg;

    localparam int ANGLE_BITS = 14;
    localparam int SUM_W      = 16;
    localparam int COUNT_W    = 15;
    localparam int STEP_W     = $clog2(SUM_W);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [SUM_W-1:0]   SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0]   SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_READ   = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_SAT   = 2'd2;

    // Snapshot of the accumulators taken by a read item.
    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0] count;
        logic               sat;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } back_state_t;

endpackage
`default_nettype wire

/* src/evu_front.sv */
// Front end: accepts items, accumulates angle samples, snapshots on reads.
// Depends on evu_pkg.
`default_nettype none
module evu_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic                          func,
    input  wire logic [13:0]                   angle,
    output logic                               q_push,
    output evu_pkg::cmd_t                      q_data
);

    localparam int AB = evu_pkg::ANGLE_BITS;
    localparam int SW = evu_pkg::SUM_W;

    logic [AB-1:0]                 last_angle_reg, last_angle_next;
    logic [SW-1:0]                 tick_sum_reg, tick_sum_next;
    logic [evu_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic                          sat_reg, sat_next;

    logic [AB-1:0] delta_u;
    logic [SW:0]   delta_ext;
    logic [SW:0]   sum_ext;

    assign delta_u   = angle[AB-1:0] - last_angle_reg;
    assign delta_ext = {{(SW+1-AB){delta_u[AB-1]}}, delta_u};
    assign sum_ext   = {tick_sum_reg[SW-1], tick_sum_reg} + delta_ext;

    assign q_push       = accept && (func == evu_pkg::FUNC_READ);
    assign q_data.sum   = tick_sum_reg;
    assign q_data.count = count_reg;
    assign q_data.sat   = sat_reg;

    always_comb
    begin
        last_angle_next = last_angle_reg;
        tick_sum_next   = tick_sum_reg;
        count_next      = count_reg;
        sat_next        = sat_reg;
        if (accept && (func == evu_pkg::FUNC_SAMPLE))
        begin
            last_angle_next = angle[AB-1:0];
            // clamp the sum when the extra sign bit disagrees
            if (sum_ext[SW] != sum_ext[SW-1])
            begin
                tick_sum_next = sum_ext[SW] ? evu_pkg::SUM_MIN : evu_pkg::SUM_MAX;
                sat_next      = 1'b1;
            end
            else
            begin
                tick_sum_next = sum_ext[SW-1:0];
            end
            if (count_reg == evu_pkg::COUNT_MAX)
            begin
                sat_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
        else if (q_push)
        begin
            // drop the accumulators once snapshotted; keep the last angle
            tick_sum_next = '0;
            count_next    = '0;
            sat_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_angle_reg <= '0;
            tick_sum_reg   <= '0;
            count_reg      <= '0;
            sat_reg        <= 1'b0;
        end
        else
        begin
            last_angle_reg <= last_angle_next;
            tick_sum_reg   <= tick_sum_next;
            count_reg      <= count_next;
            sat_reg        <= sat_next;
        end
    end

endmodule
`default_nettype wire

/* src/evu_cmd_fifo.sv */
// Two-entry queue of read snapshots between the front and back ends.
// Depends on evu_pkg.
`default_nettype none
module evu_cmd_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  evu_pkg::cmd_t      wdata,
    output logic               full,
    input  wire logic          pop,
    output evu_pkg::cmd_t      rdata,
    output logic               empty
);

    evu_pkg::cmd_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       do_push, do_pop;

    assign full    = (fill_reg == 2'd2);
    assign empty   = (fill_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule
`default_nettype wire

/* src/evu_back.sv */
// Back end: serial restoring divider and result output register.
// Depends on evu_pkg.
`default_nettype none
module evu_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_empty,
    input  evu_pkg::cmd_t                      q_data,
    output logic                               q_pop,
    output logic                               busy,
    output logic signed [15:0]                 speed,
    output logic [14:0]                        sample_count,
    output logic [1:0]                         status,
    output logic                               empty,
    input  wire logic                          pop
);

    localparam int SW = evu_pkg::SUM_W;
    localparam int CW = evu_pkg::COUNT_W;

    evu_pkg::back_state_t         state_reg, state_next;
    logic [evu_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [SW-1:0]                rem_reg, rem_next;
    logic [SW-1:0]                quo_reg, quo_next;
    logic [CW-1:0]                div_reg, div_next;
    logic                         neg_reg, neg_next;
    logic                         sat_reg, sat_next;

    logic                         out_valid_reg, out_valid_next;
    logic [SW-1:0]                speed_reg, speed_next;
    logic [CW-1:0]                count_out_reg, count_out_next;
    logic [1:0]                   status_reg, status_next;

    logic [SW-1:0] rem_sh;
    logic [SW:0]   diff;
    logic [SW-1:0] quo_signed;
    logic          load_out;
    logic          pop_acc;

    assign rem_sh     = {rem_reg[SW-2:0], quo_reg[SW-1]};
    assign diff       = {1'b0, rem_sh} - {2'b00, div_reg};
    assign quo_signed = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign pop_acc    = pop && out_valid_reg;
    assign load_out   = (state_reg == evu_pkg::BK_DONE) && (!out_valid_reg || pop_acc);

    assign busy         = (state_reg != evu_pkg::BK_IDLE);
    assign empty        = !out_valid_reg;
    assign speed        = signed'(speed_reg);
    assign sample_count = count_out_reg;
    assign status       = status_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        div_next       = div_reg;
        neg_next       = neg_reg;
        sat_next       = sat_reg;
        q_pop          = 1'b0;
        speed_next     = speed_reg;
        count_out_next = count_out_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        if (pop_acc)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            evu_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    neg_next   = q_data.sum[SW-1];
                    quo_next   = q_data.sum[SW-1] ? (~q_data.sum + 1'b1) : q_data.sum;
                    rem_next   = '0;
                    div_next   = q_data.count;
                    sat_next   = q_data.sat;
                    step_next  = '0;
                    state_next = evu_pkg::BK_DIV;
                end
            end
            evu_pkg::BK_DIV:
            begin
                quo_next  = {quo_reg[SW-2:0], ~diff[SW]};
                rem_next  = diff[SW] ? rem_sh : diff[SW-1:0];
                step_next = step_reg + 1'b1;
                if (step_reg == evu_pkg::STEP_W'(SW - 1))
                begin
                    state_next = evu_pkg::BK_DONE;
                end
            end
            evu_pkg::BK_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    count_out_next = div_reg;
                    if (div_reg == '0)
                    begin
                        speed_next  = '0;
                        status_next = evu_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        speed_next  = quo_signed;
                        status_next = sat_reg ? evu_pkg::STATUS_SAT : evu_pkg::STATUS_OK;
                    end
                    state_next = evu_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = evu_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= evu_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg      <= step_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        div_reg       <= div_next;
        neg_reg       <= neg_next;
        sat_reg       <= sat_next;
        speed_reg     <= speed_next;
        count_out_reg <= count_out_next;
        status_reg    <= status_next;
    end

endmodule
`default_nettype wire

/* src/encoder_velocity_averager_unit.sv */
// Top level of the encoder velocity averager: front end, snapshot queue, divider back end.
// Depends on evu_pkg, evu_front, evu_cmd_fifo and evu_back.
//
// Channel   Direction  Handshake          Fields
// input     in         push / full        func, angle
// result    out        pop / empty        speed, sample_count, status
//
// A sample item is absorbed into the sum and count and yields no result.
// A read item snapshots the sum and count into the queue; the back end then loads the
// snapshot, runs it through the serial restoring divider and retires the result to the
// output register, which holds it on the ports until it is popped.
// Up to two read snapshots queue ahead of the divider; full rises while both slots hold.
// Reset (rst_n low, asynchronous) clears the sum, count, angle and all queues.
`default_nettype none
module encoder_velocity_averager_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic               func,
    input  wire logic [13:0]        angle,
    input  wire logic               pop,
    output logic                    empty,
    output logic signed [15:0]      speed,
    output logic [14:0]             sample_count,
    output logic [1:0]              status
);

    logic          accept;
    logic          q_push;
    logic          q_pop;
    logic          q_empty;
    logic          back_busy;
    evu_pkg::cmd_t q_wdata;
    evu_pkg::cmd_t q_rdata;

    // Hold off every item while the snapshot queue is full.
    assign accept = push && !full;

    evu_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .func   (func),
        .angle  (angle),
        .q_push (q_push),
        .q_data (q_wdata)
    );

    evu_cmd_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    evu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_data       (q_rdata),
        .q_pop        (q_pop),
        .busy         (back_busy),
        .speed        (speed),
        .sample_count (sample_count),
        .status       (status),
        .empty        (empty),
        .pop          (pop)
    );

`ifndef SYNTHESIS
    // An accepted read must land in the queue or in the divider.
    a_read_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && func == evu_pkg::FUNC_READ) |=> (!q_empty || back_busy))
        else $error("read item lost between front and back end");

    // A read with no samples reports zero speed.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == evu_pkg::STATUS_EMPTY) |-> (speed == 16'sd0 && sample_count == '0))
        else $error("empty read with nonzero payload");

    // A zero count always carries the empty status.
    a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && sample_count == '0) |-> (status == evu_pkg::STATUS_EMPTY))
        else $error("zero count without empty status");

    // The back end never pops the queue while dividing.
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (!back_busy && !q_empty))
        else $error("snapshot popped while back end busy");
`endif

endmodule
`default_nettype wire

/* tb/sv/encoder_velocity_averager_unit_test.sv */
// Self-checking testbench for encoder_velocity_averager_unit: queue-style push/pop driving,
// a built-in speed predictor and an in-order result checker.
// Depends on evu_pkg for the function and status codes and the accumulator widths.
`default_nettype none
module encoder_velocity_averager_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SUM_HI      = 2 ** (evu_pkg::SUM_W - 1) - 1;
    localparam int SUM_LO      = -(2 ** (evu_pkg::SUM_W - 1));
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 40;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic             func;
        logic [13:0]      angle;
    } encoder_item_t;

    typedef struct {
        logic signed [15:0] speed;
        logic [14:0]        count;
        logic [1:0]         status;
    } speed_report_t;

    // DUT ports; hold every input at a known value from time zero.
    logic               clk;
    logic               rst_n = 1'b0;
    logic               push  = 1'b0;
    logic               func  = evu_pkg::FUNC_SAMPLE;
    logic [13:0]        angle = '0;
    logic               pop   = 1'b0;
    logic               full;
    logic               empty;
    logic signed [15:0] speed;
    logic [14:0]        sample_count;
    logic [1:0]         status;

    encoder_velocity_averager_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .func         (func),
        .angle        (angle),
        .pop          (pop),
        .empty        (empty),
        .speed        (speed),
        .sample_count (sample_count),
        .status       (status)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Stimulus backlog and expected speed reports.
    encoder_item_t item_backlog[$];
    speed_report_t speed_reports_q[$];

    int accepted_count = 0;
    int consumed_count = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int hold_arm = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int mismatch_count = 0;

    // Predictor state: a private copy of the accumulators inside the block.
    logic [13:0]        model_last_angle;
    logic signed [15:0] acc_ticks;
    logic [14:0]        acc_count;
    logic               acc_clipped;

    logic [13:0] walk_angle = '0;

    function automatic void clear_accumulators();
        acc_ticks   = '0;
        acc_count   = '0;
        acc_clipped = 1'b0;
    endfunction

    // Fold one angle sample into the running sum and count.
    function automatic void accumulate_sample(input logic [13:0] a);
        logic [13:0]        raw_delta;
        logic signed [13:0] delta;
        int                 sum;
        raw_delta = a - model_last_angle;
        delta     = raw_delta;
        sum       = int'(acc_ticks) + int'(delta);
        if (sum > SUM_HI)
        begin
            sum = SUM_HI;
            acc_clipped = 1'b1;
        end
        else if (sum < SUM_LO)
        begin
            sum = SUM_LO;
            acc_clipped = 1'b1;
        end
        acc_ticks = 16'(sum);
        if (acc_count == evu_pkg::COUNT_MAX)
            acc_clipped = 1'b1;
        else
            acc_count = acc_count + 15'd1;
        model_last_angle = a;
    endfunction

    // Predict the report for a read item, then clear sum, count and flag.
    function automatic void report_speed();
        speed_report_t r;
        if (acc_count == '0)
        begin
            r.speed  = '0;
            r.status = evu_pkg::STATUS_EMPTY;
        end
        else
        begin
            r.speed  = 16'(int'(acc_ticks) / int'({17'd0, acc_count}));
            r.status = acc_clipped ? evu_pkg::STATUS_SAT : evu_pkg::STATUS_OK;
        end
        r.count = acc_count;
        speed_reports_q.push_back(r);
        clear_accumulators();
    endfunction

    function automatic void log_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t ns: mismatch: %s", $time, what);
    endfunction

    // Monitor: sample both handshakes at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // Input side: predict at the moment the block takes the item.
            if (push && !full)
            begin
                accepted_count++;
                if (func == evu_pkg::FUNC_SAMPLE)
                    accumulate_sample(angle);
                else
                    report_speed();
            end
            // Result side: compare against the oldest waiting report.
            if (pop && !empty)
            begin
                if (speed_reports_q.size() == 0)
                    log_mismatch($sformatf("unexpected result speed=%0d count=%0d status=%0d",
                                           speed, sample_count, status));
                else
                begin
                    speed_report_t want;
                    want = speed_reports_q.pop_front();
                    if (speed !== want.speed || sample_count !== want.count ||
                        status !== want.status)
                        log_mismatch($sformatf(
                            "expected speed=%0d count=%0d status=%0d, got %0d/%0d/%0d",
                            want.speed, want.count, want.status,
                            speed, sample_count, status));
                end
            end
        end
    end

    // Sender: advance the backlog past accepted items, then offer or idle.
    // An offered item stays on the ports until the block takes it.
    always @(negedge clk)
    begin
        logic taken;
        logic holding;
        if (rst_n)
        begin
            taken = (consumed_count < accepted_count);
            while (consumed_count < accepted_count)
            begin
                void'(item_backlog.pop_front());
                consumed_count++;
            end
            holding = push && !taken;
            if (item_backlog.size() > 0 &&
                (holding || $urandom_range(0, 99) >= sender_idle_pct))
            begin
                push  <= 1'b1;
                func  <= item_backlog[0].func;
                angle <= item_backlog[0].angle;
            end
            else
            begin
                push  <= 1'b0;
                func  <= 1'($urandom_range(0, 1));
                angle <= 14'($urandom_range(0, 16383));
            end
        end
    end

    // Receiver: stall at random, and hold off entirely while a long hold runs.
    always @(negedge clk)
    begin
        if (rst_n)
            pop <= (hold_left == 0) && ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // Long receiver hold-off, counted here; armed by bumping hold_arm.
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (hold_arm != hold_seen)
        begin
            hold_left <= HOLD_CYCLES;
            hold_seen <= hold_arm;
        end
    end

    task automatic queue_item(input logic f, input logic [13:0] a);
        encoder_item_t it;
        it.func  = f;
        it.angle = a;
        item_backlog.push_back(it);
    endtask

    // Wait until the backlog is taken and every report has come back.
    task automatic drain();
        while (item_backlog.size() != 0 || speed_reports_q.size() != 0)
            @(negedge clk);
    endtask

    // Mostly well-formed runs of samples closed by a read; the rest is
    // back-to-back reads and stray samples with no read after them.
    task automatic add_random_items(input int n);
        int added;
        int run_len;
        int span;
        int d;
        int pick;
        added = 0;
        while (added < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
            begin
                run_len = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 24)
                                                       : $urandom_range(25, 300);
                case ($urandom_range(0, 4))
                    0: span = 3;
                    1: span = 64;
                    2: span = 1024;
                    3: span = 8192;
                    default: span = -1;
                endcase
                repeat (run_len)
                begin
                    if (span < 0)
                        walk_angle = 14'($urandom_range(0, 16383));
                    else
                    begin
                        d = int'($urandom_range(0, 2 * span)) - span;
                        walk_angle = 14'(int'(walk_angle) + d);
                    end
                    queue_item(evu_pkg::FUNC_SAMPLE, walk_angle);
                end
                queue_item(evu_pkg::FUNC_READ, 14'($urandom_range(0, 16383)));
                added += run_len + 1;
            end
            else if (pick < 90)
            begin
                d = $urandom_range(1, 3);
                repeat (d)
                    queue_item(evu_pkg::FUNC_READ, 14'($urandom_range(0, 16383)));
                added += d;
            end
            else
            begin
                d = $urandom_range(1, 5);
                repeat (d)
                begin
                    walk_angle = 14'($urandom_range(0, 16383));
                    queue_item(evu_pkg::FUNC_SAMPLE, walk_angle);
                end
                added += d;
            end
        end
    endtask

    // Main sequence: reset, directed checks, random phases, pressure.
    initial
    begin
        logic [13:0] a;
        int          i;
        model_last_angle = '0;
        clear_accumulators();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Read before any sample; then the first sample is taken from angle zero.
        queue_item(evu_pkg::FUNC_READ, 14'd0);
        queue_item(evu_pkg::FUNC_SAMPLE, 14'd8192);
        queue_item(evu_pkg::FUNC_READ, 14'h3FFF);
        queue_item(evu_pkg::FUNC_READ, 14'd0);
        // Extremes of the angle and a wrap through zero in both directions.
        queue_item(evu_pkg::FUNC_SAMPLE, 14'h3FFF);
        queue_item(evu_pkg::FUNC_SAMPLE, 14'd0);
        queue_item(evu_pkg::FUNC_SAMPLE, 14'h3FFF);
        queue_item(evu_pkg::FUNC_READ, 14'd0);
        // Drive the sum into its positive clip with the largest forward step.
        a = 14'h3FFF;
        for (i = 0; i < 5; i++)
        begin
            a = a + 14'd8191;
            queue_item(evu_pkg::FUNC_SAMPLE, a);
        end
        queue_item(evu_pkg::FUNC_READ, 14'd0);
        // Then into its negative clip with the largest backward step.
        for (i = 0; i < 5; i++)
        begin
            a = a + 14'd8192;
            queue_item(evu_pkg::FUNC_SAMPLE, a);
        end
        queue_item(evu_pkg::FUNC_READ, 14'd0);
        // Largest unclipped average.
        for (i = 0; i < 4; i++)
        begin
            a = a + 14'd8191;
            queue_item(evu_pkg::FUNC_SAMPLE, a);
        end
        queue_item(evu_pkg::FUNC_READ, 14'd0);
        walk_angle = a;
        drain();

        // Random phases, one per idling pattern.
        add_random_items(360);
        drain();

        sender_idle_pct = 62;
        add_random_items(360);
        drain();

        sender_idle_pct    = 0;
        receiver_stall_pct = 62;
        add_random_items(360);
        drain();

        sender_idle_pct    = 35;
        receiver_stall_pct = 35;
        add_random_items(370);
        drain();

        // Hold the receiver off while a dense stream of reads fills the block.
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_arm++;
        for (i = 0; i < 12; i++)
        begin
            walk_angle = 14'($urandom_range(0, 16383));
            queue_item(evu_pkg::FUNC_SAMPLE, walk_angle);
            queue_item(evu_pkg::FUNC_READ, 14'($urandom_range(0, 16383)));
        end
        drain();

        // Let any late or stray result surface before the verdict.
        repeat (SETTLE) @(negedge clk);
        if (speed_reports_q.size() != 0)
            log_mismatch($sformatf("%0d reports never arrived", speed_reports_q.size()));

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: well beyond the slowest legal run.
    initial
    begin
        #8_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire

/* files.f */
src/evu_pkg.sv
src/evu_front.sv
src/evu_cmd_fifo.sv
src/evu_back.sv
src/encoder_velocity_averager_unit.sv
tb/sv/encoder_velocity_averager_unit_test.sv
